>>> sv/quaternion_to_euler_zyx_top_defines.svh
// Assertion macros used by the port-level checker of the quaternion to Euler block
`ifndef QUATERNION_TO_EULER_ZYX_TOP_DEFINES_SVH
`define QUATERNION_TO_EULER_ZYX_TOP_DEFINES_SVH

// clocked assertion, ignored while reset is low
`define Q2E_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// a stalled transaction keeps valid high and its payload unchanged
`define Q2E_ASSERT_HOLD(label, vld, rdy, sig, msg) \
    `Q2E_ASSERT(label, (vld) && !(rdy) |=> (vld) && $stable(sig), msg)

`endif

>>> sv/q2e_pkg.sv
// Package with widths, types, constants and helper functions of the quaternion to Euler block
`timescale 1ns / 1ps
`default_nettype none
package q2e_pkg;

    localparam int QUAT_BITS       = 16;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CORDIC_STAGES   = 18;
    localparam int ANG_OUT_BITS    = 25;

    localparam int Q_FRAC   = 30;
    localparam int PROD_SH  = 2 * (QUAT_BITS - 2) - Q_FRAC;
    localparam int PROD_LSH = (PROD_SH < 0) ? -PROD_SH : 0;
    localparam int PROD_RSH = (PROD_SH > 0) ? PROD_SH : 0;

    localparam int PQ_W  = 34;   // one product in Q30
    localparam int SC_W  = 36;   // sine/cosine terms in Q30
    localparam int CW    = 40;   // CORDIC x/y datapath
    localparam int ZW    = 34;   // CORDIC angle accumulator, Q30 radians
    localparam int SQ_W  = 62;   // square root datapath
    localparam int REM_W = 2 * Q_FRAC + 1;
    localparam int ROOT_W     = Q_FRAC + 1;
    localparam int SQRT_STEPS = Q_FRAC + 1;
    localparam int MAG_W      = Q_FRAC;

    localparam int LANES      = 3;
    localparam int LANE_ROLL  = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_YAW   = 2;

    localparam int TDATA_IN_W  = ((4 * QUAT_BITS + 7) / 8) * 8;
    localparam int TDATA_OUT_W = ((3 * ANG_OUT_BITS + 7) / 8) * 8;

    typedef logic signed [QUAT_BITS-1:0]    q_t;
    typedef logic signed [PQ_W-1:0]         pq_t;
    typedef logic signed [SC_W-1:0]         sc_t;
    typedef logic signed [ZW-1:0]           z_t;
    typedef logic        [ANG_OUT_BITS-1:0] ang_t;

    localparam sc_t ONE_Q30 = sc_t'(64'sd1 <<< Q_FRAC);
    localparam z_t  PI_Q30      = 34'sd3373259426;
    localparam z_t  HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [63:0] RAD2DEG_Q24 = 64'sd961263669;
    localparam logic signed [63:0] DEG_LIM = 64'sd180 <<< ANGLE_FRAC_BITS;
    localparam logic [REM_W-1:0] REM_ONE = REM_W'(1) << (2 * Q_FRAC);

    typedef struct packed {
        sc_t  s_roll;
        sc_t  c_roll;
        sc_t  s_pitch;
        sc_t  s_yaw;
        sc_t  c_yaw;
        logic clamp;
    } q2e_item_t;

    typedef struct packed {
        sc_t [LANES-1:0] y;
        sc_t [LANES-1:0] x;
        logic            clamp;
        logic            neg;
    } q2e_cin_t;

    typedef struct packed {
        z_t [LANES-1:0] z;
        logic           clamp;
        logic           neg;
    } q2e_cout_t;

    typedef struct packed {
        ang_t roll;
        ang_t pitch;
        ang_t yaw;
        logic clamp;
    } q2e_res_t;

    // product of two quaternion parts brought to Q30 with a floor shift
    function automatic pq_t mul_q30(q_t a, q_t b);
        logic signed [2*QUAT_BITS-1:0] p;
        logic signed [65:0]            e;
        p = a * b;
        e = 66'(p);
        return PQ_W'((e <<< PROD_LSH) >>> PROD_RSH);
    endfunction

    // atan(2^-i) in Q30 radians
    function automatic z_t atan_q30(logic [4:0] i);
        z_t r;
        case (i)
            5'd0:    r = 34'sd843314857;
            5'd1:    r = 34'sd497837829;
            5'd2:    r = 34'sd263043837;
            5'd3:    r = 34'sd133525159;
            5'd4:    r = 34'sd67021687;
            5'd5:    r = 34'sd33543516;
            5'd6:    r = 34'sd16775851;
            5'd7:    r = 34'sd8388437;
            5'd8:    r = 34'sd4194283;
            5'd9:    r = 34'sd2097149;
            5'd31:   r = 34'sd0;
            default: r = z_t'(34'sd1 <<< (5'd30 - i));
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> sv/q2e_prod.sv
// Front stages: products, sine/cosine terms, pitch pole test and the square for the root
`timescale 1ns / 1ps
`default_nettype none
module q2e_prod
    import q2e_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire logic      in_valid,
    input  wire q_t        quat_w,
    input  wire q_t        quat_x,
    input  wire q_t        quat_y,
    input  wire q_t        quat_z,
    output logic           out_valid,
    output q2e_item_t      out_item,
    output logic [REM_W-1:0] out_rem
);

    logic      va_reg, vb_reg, vc_reg, vd_reg;
    pq_t       wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg, wz_reg, xy_reg, zz_reg;
    q2e_item_t item_b_reg, item_b_next;
    q2e_item_t item_c_reg, item_c_next;
    q2e_item_t item_d_reg;
    logic [2*MAG_W-1:0] sq_reg;
    logic [REM_W-1:0]   rem_reg;
    sc_t                mag;
    logic [MAG_W-1:0]   mag_lo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_comb
    begin
        item_b_next         = '0;
        item_b_next.s_roll  = (sc_t'(wx_reg) + sc_t'(yz_reg)) <<< 1;
        item_b_next.c_roll  = ONE_Q30 - ((sc_t'(xx_reg) + sc_t'(yy_reg)) <<< 1);
        item_b_next.s_pitch = (sc_t'(wy_reg) - sc_t'(zx_reg)) <<< 1;
        item_b_next.s_yaw   = (sc_t'(wz_reg) + sc_t'(xy_reg)) <<< 1;
        item_b_next.c_yaw   = ONE_Q30 - ((sc_t'(yy_reg) + sc_t'(zz_reg)) <<< 1);
    end

    always_comb
    begin
        item_c_next       = item_b_reg;
        item_c_next.clamp = (item_b_reg.s_pitch >= ONE_Q30) || (item_b_reg.s_pitch <= -ONE_Q30);
        mag               = (item_b_reg.s_pitch < 0) ? -item_b_reg.s_pitch : item_b_reg.s_pitch;
        mag_lo            = mag[MAG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg     <= mul_q30(quat_w, quat_x);
            yz_reg     <= mul_q30(quat_y, quat_z);
            xx_reg     <= mul_q30(quat_x, quat_x);
            yy_reg     <= mul_q30(quat_y, quat_y);
            wy_reg     <= mul_q30(quat_w, quat_y);
            zx_reg     <= mul_q30(quat_z, quat_x);
            wz_reg     <= mul_q30(quat_w, quat_z);
            xy_reg     <= mul_q30(quat_x, quat_y);
            zz_reg     <= mul_q30(quat_z, quat_z);
            item_b_reg <= item_b_next;
            item_c_reg <= item_c_next;
            sq_reg     <= mag_lo * mag_lo;
            item_d_reg <= item_c_reg;
            rem_reg    <= REM_ONE - REM_W'(sq_reg);
        end
    end

    assign out_valid = vd_reg;
    assign out_item  = item_d_reg;
    assign out_rem   = rem_reg;

endmodule
`default_nettype wire

>>> sv/q2e_sqrt.sv
// Floor integer square root, one result bit per pipeline stage, item data riding along
`timescale 1ns / 1ps
`default_nettype none
module q2e_sqrt
    import q2e_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire q2e_item_t        in_item,
    input  wire logic [REM_W-1:0] in_rem,
    output logic                  out_valid,
    output q2e_item_t             out_item,
    output logic [ROOT_W-1:0]     out_root
);

    logic [SQ_W-1:0] v_reg   [SQRT_STEPS];
    logic [SQ_W-1:0] res_reg [SQRT_STEPS];
    q2e_item_t       item_reg[SQRT_STEPS];
    logic            valid_reg[SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
        logic [SQ_W-1:0] v_cur, r_cur, t;
        q2e_item_t       item_cur;
        logic            valid_cur;

        if (k == 0)
        begin : g_first
            assign v_cur     = SQ_W'(in_rem);
            assign r_cur     = '0;
            assign item_cur  = in_item;
            assign valid_cur = in_valid;
        end
        else
        begin : g_rest
            assign v_cur     = v_reg[k-1];
            assign r_cur     = res_reg[k-1];
            assign item_cur  = item_reg[k-1];
            assign valid_cur = valid_reg[k-1];
        end

        assign t = r_cur + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                item_reg[k] <= item_cur;
                if (v_cur >= t)
                begin
                    v_reg[k]   <= v_cur - t;
                    res_reg[k] <= (r_cur >> 1) + BIT;
                end
                else
                begin
                    v_reg[k]   <= v_cur;
                    res_reg[k] <= r_cur >> 1;
                end
            end
        end
    end

    assign out_valid = valid_reg[SQRT_STEPS-1];
    assign out_item  = item_reg[SQRT_STEPS-1];
    assign out_root  = res_reg[SQRT_STEPS-1][ROOT_W-1:0];

endmodule
`default_nettype wire

>>> sv/q2e_cordic.sv
// Three parallel pipelined CORDIC vectoring lanes computing atan2(y, x) in Q30 radians
`timescale 1ns / 1ps
`default_nettype none
module q2e_cordic
    import q2e_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire logic     in_valid,
    input  wire q2e_cin_t cin,
    output logic          out_valid,
    output q2e_cout_t     cout
);

    logic valid_reg[CORDIC_STAGES+1];
    logic clamp_reg[CORDIC_STAGES+1];
    logic neg_reg  [CORDIC_STAGES+1];
    z_t   z_out    [LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= CORDIC_STAGES; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i <= CORDIC_STAGES; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            clamp_reg[0] <= cin.clamp;
            neg_reg[0]   <= cin.neg;
            for (int i = 1; i <= CORDIC_STAGES; i++)
            begin
                clamp_reg[i] <= clamp_reg[i-1];
                neg_reg[i]   <= neg_reg[i-1];
            end
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        sc_t  xi, yi;
        logic signed [CW-1:0] x0, y0;
        z_t   z0;
        logic signed [CW-1:0] x_reg[CORDIC_STAGES+1];
        logic signed [CW-1:0] y_reg[CORDIC_STAGES+1];
        z_t   z_reg   [CORDIC_STAGES+1];
        logic zero_reg[CORDIC_STAGES+1];

        assign xi = $signed(cin.x[l]);
        assign yi = $signed(cin.y[l]);

        // left half plane: quarter turn into the right half first
        always_comb
        begin
            x0 = CW'(xi);
            y0 = CW'(yi);
            z0 = '0;
            if (xi < 0)
            begin
                if (yi >= 0)
                begin
                    x0 = CW'(yi);
                    y0 = -CW'(xi);
                    z0 = HALF_PI_Q30;
                end
                else
                begin
                    x0 = -CW'(yi);
                    y0 = CW'(xi);
                    z0 = -HALF_PI_Q30;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[0]    <= x0;
                y_reg[0]    <= y0;
                z_reg[0]    <= z0;
                zero_reg[0] <= (xi == '0) && (yi == '0);
            end
        end

        for (genvar i = 0; i < CORDIC_STAGES; i++)
        begin : g_iter
            localparam logic [4:0] IDX = 5'(i);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    zero_reg[i+1] <= zero_reg[i];
                    if (y_reg[i] >= 0)
                    begin
                        x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] + atan_q30(IDX);
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] - atan_q30(IDX);
                    end
                end
            end
        end

        assign z_out[l] = zero_reg[CORDIC_STAGES] ? '0 : z_reg[CORDIC_STAGES];
    end

    always_comb
    begin
        cout       = '0;
        for (int l = 0; l < LANES; l++)
            cout.z[l] = z_out[l];
        cout.clamp = clamp_reg[CORDIC_STAGES];
        cout.neg   = neg_reg[CORDIC_STAGES];
    end

    assign out_valid = valid_reg[CORDIC_STAGES];

endmodule
`default_nettype wire

>>> sv/q2e_out.sv
// Output stages: pole override, range limit, unit conversion, rounding, result register
`timescale 1ns / 1ps
`default_nettype none
module q2e_out
    import q2e_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire logic      in_valid,
    input  wire q2e_cout_t cin,
    input  wire logic      angle_unit,
    output logic           out_valid,
    output q2e_res_t       res
);

    logic v1_reg, v2_reg;
    logic unit1_reg, clamp1_reg, clamp2_reg;
    z_t   a_next  [LANES];
    z_t   a1_reg  [LANES];
    logic signed [63:0] p1_reg[LANES];
    ang_t r_next  [LANES];
    ang_t r2_reg  [LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            a_next[l] = $signed(cin.z[l]);
            if (a_next[l] > PI_Q30)
                a_next[l] = PI_Q30;
            if (a_next[l] < -PI_Q30)
                a_next[l] = -PI_Q30;
        end
        if (cin.clamp)
            a_next[LANE_PITCH] = cin.neg ? -HALF_PI_Q30 : HALF_PI_Q30;
    end

    always_comb
    begin
        logic signed [63:0] r;
        r = '0;
        for (int l = 0; l < LANES; l++)
        begin
            if (unit1_reg)
            begin
                r = (p1_reg[l] + (64'sd1 <<< (53 - ANGLE_FRAC_BITS))) >>> (54 - ANGLE_FRAC_BITS);
                if (r > DEG_LIM)
                    r = DEG_LIM;
                if (r < -DEG_LIM)
                    r = -DEG_LIM;
            end
            else
                r = (64'(a1_reg[l]) + (64'sd1 <<< (29 - ANGLE_FRAC_BITS)))
                    >>> (Q_FRAC - ANGLE_FRAC_BITS);
            r_next[l] = r[ANG_OUT_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unit1_reg  <= angle_unit;
            clamp1_reg <= cin.clamp;
            clamp2_reg <= clamp1_reg;
            for (int l = 0; l < LANES; l++)
            begin
                a1_reg[l] <= a_next[l];
                p1_reg[l] <= 64'(a_next[l]) * RAD2DEG_Q24;
                r2_reg[l] <= r_next[l];
            end
        end
    end

    assign out_valid = v2_reg;
    assign res.roll  = r2_reg[LANE_ROLL];
    assign res.pitch = r2_reg[LANE_PITCH];
    assign res.yaw   = r2_reg[LANE_YAW];
    assign res.clamp = clamp2_reg;

endmodule
`default_nettype wire

>>> sv/quaternion_to_euler_zyx_top.sv
// Top level of the quaternion to Z-Y-X Euler angle converter
//
// Takes one quaternion per transaction and returns roll, pitch and yaw in
// radians or degrees (16 fraction bits), plus a flag when pitch sits at a
// pole and was clamped to +-90 degrees. The pipeline accepts a new item on
// every cycle in which the output is not stalled; it is made of 4 front
// stages (products, sums, pole test with square, remainder), 31 stages of
// the bit-per-stage square root that feeds the pitch lane, 19 CORDIC stages
// (quadrant fold plus 18 iterations) and 2 output stages (degree multiply,
// rounding). When the output is stalled the whole pipeline holds. Change
// cfg_wdata (0 radians, 1 degrees) only while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_zyx_top
    import q2e_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z
    input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // roll_angle, pitch_angle, yaw_angle, zero pad
    output logic [TDATA_OUT_W-1:0]      m_axis_tdata,
    // pitch_clamped
    output logic                        m_axis_tuser
);

    logic      angle_unit_reg;
    logic      en;
    logic      prod_valid, sqrt_valid, cordic_valid, out_valid;
    q2e_item_t prod_item, sqrt_item;
    logic [REM_W-1:0]  prod_rem;
    logic [ROOT_W-1:0] sqrt_root;
    q2e_cin_t  cin;
    q2e_cout_t cout;
    q2e_res_t  res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            angle_unit_reg <= 1'b0;
        else if (cfg_we)
            angle_unit_reg <= cfg_wdata;
    end

    assign en            = !out_valid || m_axis_tready;
    assign s_axis_tready = en;

    q2e_prod u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .quat_w    (s_axis_tdata[QUAT_BITS-1:0]),
        .quat_x    (s_axis_tdata[2*QUAT_BITS-1:QUAT_BITS]),
        .quat_y    (s_axis_tdata[3*QUAT_BITS-1:2*QUAT_BITS]),
        .quat_z    (s_axis_tdata[4*QUAT_BITS-1:3*QUAT_BITS]),
        .out_valid (prod_valid),
        .out_item  (prod_item),
        .out_rem   (prod_rem)
    );

    q2e_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prod_valid),
        .in_item   (prod_item),
        .in_rem    (prod_rem),
        .out_valid (sqrt_valid),
        .out_item  (sqrt_item),
        .out_root  (sqrt_root)
    );

    always_comb
    begin
        cin               = '0;
        cin.y[LANE_ROLL]  = sqrt_item.s_roll;
        cin.x[LANE_ROLL]  = sqrt_item.c_roll;
        cin.y[LANE_PITCH] = sqrt_item.s_pitch;
        cin.x[LANE_PITCH] = sc_t'(sqrt_root);
        cin.y[LANE_YAW]   = sqrt_item.s_yaw;
        cin.x[LANE_YAW]   = sqrt_item.c_yaw;
        cin.clamp         = sqrt_item.clamp;
        cin.neg           = sqrt_item.s_pitch < 0;
    end

    q2e_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqrt_valid),
        .cin       (cin),
        .out_valid (cordic_valid),
        .cout      (cout)
    );

    q2e_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (cordic_valid),
        .cin        (cout),
        .angle_unit (angle_unit_reg),
        .out_valid  (out_valid),
        .res        (res)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = TDATA_OUT_W'({res.yaw, res.pitch, res.roll});
    assign m_axis_tuser  = res.clamp;

endmodule
`default_nettype wire

>>> sv/q2e_checker.sv
// Port-level assertions for the quaternion to Euler block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_to_euler_zyx_top_defines.svh"
module q2e_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [79:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    `Q2E_ASSERT_HOLD(a_out_hold, m_axis_tvalid, m_axis_tready, {m_axis_tdata, m_axis_tuser}, "output changed while stalled")
    `Q2E_ASSERT(a_ready_follows_out, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not track output stall")
    `Q2E_ASSERT(a_angle_range, m_axis_tvalid |-> ($signed(m_axis_tdata[24:0]) <= 25'sd11796480) && ($signed(m_axis_tdata[24:0]) >= -25'sd11796480) && ($signed(m_axis_tdata[49:25]) <= 25'sd11796480) && ($signed(m_axis_tdata[49:25]) >= -25'sd11796480) && ($signed(m_axis_tdata[74:50]) <= 25'sd11796480) && ($signed(m_axis_tdata[74:50]) >= -25'sd11796480), "angle out of range")
    `Q2E_ASSERT(a_clamp_pitch, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[49:25] != 25'd0, "clamped pitch is zero")

endmodule

bind quaternion_to_euler_zyx_top q2e_checker u_q2e_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

>>> bench/testbench.sv
// Self-checking testbench for the quaternion to Z-Y-X Euler angle converter
`timescale 1ns / 1ps
`default_nettype none

class euler_scoreboard;

    typedef struct {
        logic [24:0] roll;
        logic [24:0] pitch;
        logic [24:0] yaw;
        logic        clamp;
    } euler_t;

    euler_t pending_angles[$];
    bit     degrees;
    int     errors;

    longint atan_step[18] = '{843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768, 16384, 8192};

    localparam longint ONE_Q30  = 64'sd1 <<< 30;
    localparam longint PI_Q30   = 64'sd3373259426;
    localparam longint HALF_PI  = 64'sd1686629713;
    localparam longint RAD2DEG  = 64'sd961263669;

    // product in Q30: the Q28 product of the Q14 inputs shifted left by two
    function longint prod(shortint a, shortint b);
        return (longint'(a) * longint'(b)) <<< 2;
    endfunction

    function longint unsigned root_floor(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function longint vector_angle(longint y, longint x);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = HALF_PI;
            end
            else
            begin
                x = -y; y = t; z = -HALF_PI;
            end
        end
        for (int i = 0; i < 18; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += atan_step[i];
            end
            else
            begin
                x -= dx; y += dy; z -= atan_step[i];
            end
        end
        return z;
    endfunction

    function logic [24:0] scale_angle(longint a);
        longint r, lim;
        if (a > PI_Q30) a = PI_Q30;
        if (a < -PI_Q30) a = -PI_Q30;
        if (degrees)
        begin
            r = (a * RAD2DEG + (64'sd1 <<< 37)) >>> 38;
            lim = 64'sd180 <<< 16;
            if (r > lim) r = lim;
            if (r < -lim) r = -lim;
        end
        else
            r = (a + (64'sd1 <<< 13)) >>> 14;
        return r[24:0];
    endfunction

    function void note_quat(shortint w, shortint x, shortint y, shortint z);
        longint sr, cr, sp, sy, cy, pitch;
        longint unsigned sq;
        euler_t e;
        sr = 2 * (prod(w, x) + prod(y, z));
        cr = ONE_Q30 - 2 * (prod(x, x) + prod(y, y));
        sp = 2 * (prod(w, y) - prod(z, x));
        sy = 2 * (prod(w, z) + prod(x, y));
        cy = ONE_Q30 - 2 * (prod(y, y) + prod(z, z));
        e.clamp = 0;
        if (sp >= ONE_Q30 || sp <= -ONE_Q30)
        begin
            pitch = (sp > 0) ? HALF_PI : -HALF_PI;
            e.clamp = 1;
        end
        else
        begin
            sq = (sp < 0) ? longint'(-sp) * longint'(-sp) : sp * sp;
            pitch = vector_angle(sp, longint'(root_floor((64'd1 << 60) - sq)));
        end
        e.roll  = scale_angle(vector_angle(sr, cr));
        e.pitch = scale_angle(pitch);
        e.yaw   = scale_angle(vector_angle(sy, cy));
        pending_angles.push_back(e);
    endfunction

    function void check_angles(logic [24:0] roll, logic [24:0] pitch,
                               logic [24:0] yaw, logic clamp);
        euler_t e;
        if (pending_angles.size() == 0)
        begin
            $display("%0t: unexpected transaction roll=%h pitch=%h yaw=%h clamp=%b",
                     $time, roll, pitch, yaw, clamp);
            errors++;
            return;
        end
        e = pending_angles.pop_front();
        if (roll !== e.roll)
        begin
            $display("%0t: roll expected %h actual %h", $time, e.roll, roll);
            errors++;
        end
        if (pitch !== e.pitch)
        begin
            $display("%0t: pitch expected %h actual %h", $time, e.pitch, pitch);
            errors++;
        end
        if (yaw !== e.yaw)
        begin
            $display("%0t: yaw expected %h actual %h", $time, e.yaw, yaw);
            errors++;
        end
        if (clamp !== e.clamp)
        begin
            $display("%0t: pitch_clamped expected %b actual %b", $time, e.clamp, clamp);
            errors++;
        end
    endfunction

endclass

module testbench;
    import q2e_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic                   cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    euler_scoreboard angles_sb;
    int burst_left;
    int stall_mode;

    quaternion_to_euler_zyx_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial clk = 0;
    always #4 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("FAIL quaternion_to_euler_zyx_top");
        $finish;
    end

    // receiver: stall pattern switches between always ready, light and heavy stalls
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            angles_sb.check_angles(m_axis_tdata[24:0], m_axis_tdata[49:25],
                                   m_axis_tdata[74:50], m_axis_tuser);
    end

    task automatic send_quat(shortint w, shortint x, shortint y, shortint z);
        s_axis_tdata  <= {16'(z), 16'(y), 16'(x), 16'(w)};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        angles_sb.note_quat(w, x, y, z);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 20);
            if ($urandom_range(0, 2) != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
    endtask

    task automatic set_unit(bit deg);
        s_axis_tvalid <= 1'b0;
        while (angles_sb.pending_angles.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= deg;
        @(negedge clk);
        cfg_we <= 1'b0;
        angles_sb.degrees = deg;
    endtask

    task automatic run_directed();
        send_quat(0, 0, 0, 0);
        send_quat(16384, 0, 0, 0);
        send_quat(-16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);     // roll lands on +pi
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(11585, 0, 11585, 0); // just below the pole
        send_quat(11586, 0, 11586, 0); // north pole, clamped
        send_quat(11586, 0, -11586, 0); // south pole, clamped
        send_quat(0, 11586, 0, -11586);
        send_quat(32767, 32767, 32767, 32767);
        send_quat(-32768, -32768, -32768, -32768);
        send_quat(-32768, 32767, -32768, 32767);
        send_quat(32767, -32768, 32767, -32768);
        send_quat(-1, -1, -1, -1);
        send_quat(1, 0, 0, 0);
        send_quat(8192, 8192, 8192, 8192);
        send_quat(8192, -8192, 8192, -8192);
    endtask

    // mostly components within +-1.0, some full-range noise and near-pole cases
    task automatic run_random(int count);
        shortint w, x, y, z;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    w = $urandom; x = $urandom; y = $urandom; z = $urandom;
                end
                2:
                begin
                    w = 11586 + $urandom_range(0, 40) - 20;
                    y = (($urandom & 1) ? w : -w) + $urandom_range(0, 6) - 3;
                    x = $urandom_range(0, 200) - 100;
                    z = $urandom_range(0, 200) - 100;
                end
                default:
                begin
                    w = $urandom_range(0, 32768) - 16384;
                    x = $urandom_range(0, 32768) - 16384;
                    y = $urandom_range(0, 32768) - 16384;
                    z = $urandom_range(0, 32768) - 16384;
                end
            endcase
            send_quat(w, x, y, z);
        end
    endtask

    initial
    begin
        angles_sb     = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        stall_mode    = 0;
        burst_left    = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();
        run_random(200);
        set_unit(1'b1);
        run_directed();
        run_random(200);
        set_unit(1'b0);
        run_random(200);

        s_axis_tvalid <= 1'b0;
        while (angles_sb.pending_angles.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (angles_sb.errors == 0)
            $display("PASS quaternion_to_euler_zyx_top");
        else
            $display("FAIL quaternion_to_euler_zyx_top");
        $finish;
    end

endmodule
`default_nettype wire

>>> files.f
+incdir+sv
sv/q2e_pkg.sv
sv/q2e_prod.sv
sv/q2e_sqrt.sv
sv/q2e_cordic.sv
sv/q2e_out.sv
sv/quaternion_to_euler_zyx_top.sv
sv/q2e_checker.sv
bench/testbench.sv
